// ===== design/rbsm_pkg.sv =====
package rbsm_pkg;

	// fixed field widths
	localparam int CNT_W     = 32;
	localparam int LEN_W     = 17;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;

	// largest ring the ring_bytes register can express
	localparam int RING_REG_MAX = 131071;

	localparam int MAX_RING_BYTES_DEF = 65536;

	localparam logic [LEN_W-1:0] RING_BYTES_RST = LEN_W'(4096);
	localparam logic [CNT_W-1:0] DATA_BASE_RST  = '0;

	// request modes, also used as result kinds
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SYNC  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RING_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE  = 1'b1;

endpackage

// ===== design/rbsm_div.sv =====
module rbsm_div #(
	parameter int DIV_W = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rbsm_pkg::CNT_W-1:0] dividend,
	input  logic [DIV_W-1:0]           divisor,
	output logic                       done,
	output logic [DIV_W-1:0]           remainder
);
	import rbsm_pkg::*;

	localparam int STEP_W = $clog2(CNT_W);

	logic [CNT_W-1:0]  dvd_q;
	logic [DIV_W:0]    rem_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] trial;

	// restoring step: shift in next dividend bit, subtract if it fits
	assign rem_sh = {rem_q[DIV_W-1:0], dvd_q[CNT_W-1]};
	assign trial  = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && run_q && (step_q == STEP_W'(CNT_W - 1));
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CNT_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
			rem_q <= trial[DIV_W] ? rem_sh : trial;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[DIV_W-1:0];

endmodule

// ===== design/ring_buffer_segment_manager_top.sv =====
// ring buffer segment manager
//
// keeps free-running 32-bit written, read and synced byte counters for a
// byte ring and turns each request into one or two result segments
// - request channel: start/busy; a request is taken at a clock edge with
//   start high and busy low. mode selects write grant, read grant or sync;
//   mode 3 is taken and dropped without a result
// - result channel: strobe marks each result for one cycle, last marks the
//   final one; the receiver cannot stall, results always go out
// - config channel: cfg_valid/cfg_ready (always ready) with cfg_index and
//   cfg_data; write it only while busy is low and no result is pending
// - sequence: a write or read request runs one division on its counter, a
//   sync a second one on the synced counter; the limit, grant and emit
//   states follow, and a second segment follows in the next cycle.
//   busy stays high until the final result goes out, the index is found by
//   a shared restoring divider taking one quotient bit per cycle, with two
//   counters for a sync; a new request is taken only once busy is low, so
//   the block takes no new request while it is still working on one
// - reset clears all three counters, ring_bytes to 4096, data_base to 0
module ring_buffer_segment_manager_top #(
	parameter int MAX_RING_BYTES = rbsm_pkg::MAX_RING_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           start,
	output logic                           busy,
	input  logic [rbsm_pkg::MODE_W-1:0]    mode,
	input  logic [rbsm_pkg::CNT_W-1:0]     request_length,
	// config channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rbsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbsm_pkg::CNT_W-1:0]     cfg_data,
	// result channel
	output logic                           strobe,
	output logic [rbsm_pkg::MODE_W-1:0]    kind,
	output logic [rbsm_pkg::CNT_W-1:0]     offset,
	output logic [rbsm_pkg::LEN_W-1:0]     length,
	output logic [rbsm_pkg::LEN_W-1:0]     granted,
	output logic                           last
);
	import rbsm_pkg::*;

	// effective ring size limit and the width of ring indexes
	localparam int RS_MAX = (MAX_RING_BYTES > RING_REG_MAX) ? RING_REG_MAX : MAX_RING_BYTES;
	localparam int RS_W   = $clog2(RS_MAX + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIVA  = 7'b0000010,   // index of written or read counter
		S_DIVB  = 7'b0000100,   // index of synced counter (sync only)
		S_LIM   = 7'b0001000,   // clamp fill, find available bytes
		S_GRANT = 7'b0010000,   // grant size and start index
		S_EMIT  = 7'b0100000,   // first result, counter update
		S_OUT2  = 7'b1000000    // second segment after the wrap
	} state_t;

	state_t state_q;

	// configuration registers
	logic [LEN_W-1:0] ring_bytes_q;
	logic [CNT_W-1:0] data_base_q;

	// free-running counters
	logic [CNT_W-1:0] written_q;
	logic [CNT_W-1:0] read_q;
	logic [CNT_W-1:0] synced_q;

	// request context
	logic [MODE_W-1:0] mode_q;
	logic [CNT_W-1:0]  req_q;
	logic [RS_W-1:0]   rs_q;
	logic [CNT_W-1:0]  diff_q;
	logic [RS_W-1:0]   aidx_q;     // write or read ring index
	logic [RS_W-1:0]   sidx_q;     // sync start index, then start index
	logic [RS_W-1:0]   avail_q;
	logic              empty_q;
	logic              whole_q;
	logic [RS_W-1:0]   grant_q;
	logic [RS_W-1:0]   first_q;
	logic [RS_W-1:0]   len2_q;

	// result registers
	logic              strobe_q;
	logic [MODE_W-1:0] kind_q;
	logic [CNT_W-1:0]  offset_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  granted_q;
	logic              last_q;

	// divider hookup
	logic             div_start;
	logic [CNT_W-1:0] div_dividend;
	logic             div_done;
	logic [RS_W-1:0]  div_rem;

	logic             accept;
	logic [RS_W-1:0]  rs_new;
	logic [RS_W-1:0]  fill_c;
	logic [CNT_W-1:0] base_sel;
	logic             single;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// ring size as used: zero reads as one, oversize clamps to the max
	always_comb begin
		if (ring_bytes_q == '0) begin
			rs_new = RS_W'(1);
		end else if (CNT_W'(ring_bytes_q) > CNT_W'(RS_MAX)) begin
			rs_new = RS_W'(RS_MAX);
		end else begin
			rs_new = ring_bytes_q[RS_W-1:0];
		end
	end

	// first division runs on the counter the request concerns, a sync
	// runs a second one on the synced counter
	assign div_start    = (accept && (mode != MODE_NONE)) ||
	                      (state_q == S_DIVA && div_done && mode_q == MODE_SYNC);
	assign div_dividend = (state_q == S_DIVA) ? synced_q :
	                      (mode == MODE_READ) ? read_q : written_q;

	rbsm_div #(
		.DIV_W (RS_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (rs_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// overfull ring counts as full
	assign fill_c   = (diff_q > CNT_W'(rs_q)) ? rs_q : diff_q[RS_W-1:0];
	assign base_sel = (mode_q == MODE_SYNC) ? data_base_q : '0;
	// one segment when the grant does not run past the ring end
	assign single   = (grant_q <= first_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_bytes_q <= RING_BYTES_RST;
			data_base_q  <= DATA_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RING_BYTES: ring_bytes_q <= cfg_data[LEN_W-1:0];
				REG_DATA_BASE:  data_base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			written_q <= '0;
			read_q    <= '0;
			synced_q  <= '0;
			strobe_q  <= 1'b0;
		end else begin
			// a result goes out after the emit and the second segment states
			strobe_q <= (state_q == S_EMIT) || (state_q == S_OUT2);
			unique case (state_q)
				S_IDLE: begin
					if (accept && (mode != MODE_NONE)) begin
						state_q <= S_DIVA;
					end
				end
				S_DIVA: begin
					if (div_done) begin
						state_q <= (mode_q == MODE_SYNC) ? S_DIVB : S_LIM;
					end
				end
				S_DIVB: begin
					if (div_done) begin
						state_q <= S_LIM;
					end
				end
				S_LIM: begin
					state_q <= S_GRANT;
				end
				S_GRANT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (grant_q != '0) begin
						unique case (mode_q)
							MODE_WRITE: written_q <= written_q + CNT_W'(grant_q);
							MODE_READ:  read_q    <= read_q + CNT_W'(grant_q);
							default:    synced_q  <= written_q;
						endcase
					end
					state_q <= (grant_q == '0 || single) ? S_IDLE : S_OUT2;
				end
				S_OUT2: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			req_q  <= request_length;
			rs_q   <= rs_new;
			diff_q <= written_q - ((mode == MODE_SYNC) ? synced_q : read_q);
		end
		if (state_q == S_DIVA && div_done) begin
			aidx_q <= div_rem;
		end
		if (state_q == S_DIVB && div_done) begin
			sidx_q <= div_rem;
		end
		if (state_q == S_LIM) begin
			avail_q <= (mode_q == MODE_WRITE) ? (rs_q - fill_c) : fill_c;
			empty_q <= (diff_q == '0);
			whole_q <= (diff_q >= CNT_W'(rs_q)) || (sidx_q == aidx_q);
		end
		if (state_q == S_GRANT) begin
			if (mode_q == MODE_SYNC) begin
				if (empty_q) begin
					sidx_q  <= aidx_q;
					grant_q <= '0;
					first_q <= rs_q - aidx_q;
				end else if (whole_q) begin
					// whole ring dirty: start at the write index
					sidx_q  <= aidx_q;
					grant_q <= rs_q;
					first_q <= rs_q - aidx_q;
				end else begin
					grant_q <= (sidx_q < aidx_q) ? (aidx_q - sidx_q)
					                             : (rs_q - sidx_q + aidx_q);
					first_q <= rs_q - sidx_q;
				end
			end else begin
				sidx_q  <= aidx_q;
				grant_q <= (req_q < CNT_W'(avail_q)) ? req_q[RS_W-1:0] : avail_q;
				first_q <= rs_q - aidx_q;
			end
		end
		if (state_q == S_EMIT) begin
			kind_q    <= mode_q;
			offset_q  <= base_sel + CNT_W'(sidx_q);
			granted_q <= LEN_W'(grant_q);
			if (grant_q == '0 || single) begin
				length_q <= LEN_W'(grant_q);
				last_q   <= 1'b1;
			end else begin
				length_q <= LEN_W'(first_q);
				last_q   <= 1'b0;
			end
			len2_q <= grant_q - first_q;
		end
		if (state_q == S_OUT2) begin
			offset_q <= base_sel;
			length_q <= LEN_W'(len2_q);
			last_q   <= 1'b1;
		end
	end

	assign strobe  = strobe_q;
	assign kind    = kind_q;
	assign offset  = offset_q;
	assign length  = length_q;
	assign granted = granted_q;
	assign last    = last_q;

	// the second segment state only comes while an open first segment is out
	a_out2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT2 |-> strobe && !last)
		else $error("second segment without open first segment");

	// a taken request with a valid mode keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode != MODE_NONE) |=> busy)
		else $error("request taken but block not busy");

	// no segment is longer than the whole grant
	a_len_in_grant: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> length <= granted)
		else $error("segment longer than grant");

	// a nonempty grant never closes with an empty segment
	a_last_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> (granted == '0) || (length != '0))
		else $error("empty final segment of a nonempty grant");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import rbsm_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 9;
	// worst case request latency (sync) plus some margin
	localparam int DRAIN_CYCLES  = 80;
	// cycles without any handshake or result before the run is declared hung
	localparam int STALL_LIMIT   = 2000;
	localparam int RING_MAX      = MAX_RING_BYTES_DEF;
	localparam int N_PHASES      = 13;
	localparam int PHASE_ITEMS   = 96;

	// one result as it appears on the result ports
	typedef struct packed {
		logic [MODE_W-1:0] kind;
		logic [CNT_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  granted;
		logic              last;
	} seg_t;

	// directed request: n_typed < 0 means the predictor supplies the results,
	// otherwise n_typed results (0 or 1) are given right here
	typedef struct {
		logic [MODE_W-1:0] op;
		logic [CNT_W-1:0]  req;
		int                n_typed;
		seg_t              want;
	} dir_row_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 start          = 1'b0;
	logic [MODE_W-1:0]    mode           = MODE_WRITE;
	logic [CNT_W-1:0]     request_length = '0;
	logic                 cfg_valid      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = REG_RING_BYTES;
	logic [CNT_W-1:0]     cfg_data       = '0;
	logic                 busy;
	logic                 cfg_ready;
	logic                 strobe;
	logic [MODE_W-1:0]    kind;
	logic [CNT_W-1:0]     offset;
	logic [LEN_W-1:0]     length;
	logic [LEN_W-1:0]     granted;
	logic                 last;

	// shadow of the block state, tracked at every accepted request and register write
	logic [CNT_W-1:0] wr_total  = '0;
	logic [CNT_W-1:0] rd_total  = '0;
	logic [CNT_W-1:0] sync_mark = '0;
	logic [LEN_W-1:0] ring_reg  = RING_BYTES_RST;
	logic [CNT_W-1:0] base_reg  = DATA_BASE_RST;

	seg_t segs_due [$];   // results still owed by the block, oldest first
	seg_t fresh [$];      // results of the request just taken
	int   typed_n = -1;   // hand-written expectation of the request on the port
	seg_t typed_seg = '0;
	int   n_errors = 0;
	int unsigned quiet = 0;

	// reset state: ring of 4096, data base 0, all counters 0
	dir_row_t dir_rows [22] = '{
		// nothing written yet: empty read grant and empty sync
		'{MODE_READ,  32'd100,        1, '{MODE_READ,  32'd0, 17'd0,    17'd0,    1'b1}},
		'{MODE_SYNC,  32'd0,          1, '{MODE_SYNC,  32'd0, 17'd0,    17'd0,    1'b1}},
		// unknown mode is dropped without a result
		'{MODE_NONE,  32'hFFFF_FFFF,  0, '0},
		'{MODE_WRITE, 32'd0,          1, '{MODE_WRITE, 32'd0, 17'd0,    17'd0,    1'b1}},
		// largest request fills the whole ring in one segment
		'{MODE_WRITE, 32'hFFFF_FFFF,  1, '{MODE_WRITE, 32'd0, 17'd4096, 17'd4096, 1'b1}},
		// ring full: no free space left
		'{MODE_WRITE, 32'd1,          1, '{MODE_WRITE, 32'd0, 17'd0,    17'd0,    1'b1}},
		'{MODE_READ,  32'd0,          1, '{MODE_READ,  32'd0, 17'd0,    17'd0,    1'b1}},
		// whole ring dirty with the write index at 0: a single range
		'{MODE_SYNC,  32'd0,          1, '{MODE_SYNC,  32'd0, 17'd4096, 17'd4096, 1'b1}},
		// length is ignored on sync; nothing new since the last one
		'{MODE_SYNC,  32'hFFFF_FFFF,  1, '{MODE_SYNC,  32'd0, 17'd0,    17'd0,    1'b1}},
		'{MODE_READ,  32'd4000,       1, '{MODE_READ,  32'd0, 17'd4000, 17'd4000, 1'b1}},
		'{MODE_WRITE, 32'd200,        1, '{MODE_WRITE, 32'd0, 17'd200,  17'd200,  1'b1}},
		// read across the ring end, then write across it
		'{MODE_READ,  32'd500,       -1, '0},
		'{MODE_WRITE, 32'd4000,      -1, '0},
		// more than a ring written since the last sync
		'{MODE_SYNC,  32'd0,         -1, '0},
		'{MODE_WRITE, 32'd50,        -1, '0},
		'{MODE_SYNC,  32'd0,         -1, '0},
		'{MODE_READ,  32'hFFFF_FFFF, -1, '0},
		'{MODE_WRITE, 32'd4000,      -1, '0},
		// partial sync that wraps: two ranges
		'{MODE_SYNC,  32'd0,         -1, '0},
		'{MODE_WRITE, 32'd4096,      -1, '0},
		'{MODE_SYNC,  32'd0,         -1, '0},
		'{MODE_NONE,  32'd0,          0, '0}
	};

	ring_buffer_segment_manager_top #(
		.MAX_RING_BYTES(RING_MAX)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.request_length(request_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.kind          (kind),
		.offset        (offset),
		.length        (length),
		.granted       (granted),
		.last          (last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ring size in use: 0 acts as 1, oversize values clip to the maximum
	function automatic logic [CNT_W-1:0] ring_eff();
		if (ring_reg == '0)
			return 1;
		if (ring_reg > RING_MAX)
			return RING_MAX;
		return CNT_W'(ring_reg);
	endfunction

	// results of one request, and the counter update it causes
	function automatic void compute_segments(input logic [MODE_W-1:0] m,
			input logic [CNT_W-1:0] req);
		logic [CNT_W-1:0] rs, fill, idx, avail, g, room, diff, widx, sidx, total;
		rs = ring_eff();
		fill = wr_total - rd_total;
		// overfull ring after a shrink counts as exactly full
		if (fill > rs)
			fill = rs;
		fresh.delete();
		case (m)
			MODE_WRITE, MODE_READ: begin
				idx = (m == MODE_WRITE) ? wr_total % rs : rd_total % rs;
				avail = (m == MODE_WRITE) ? rs - fill : fill;
				g = (req < avail) ? req : avail;
				room = rs - idx;
				// an empty grant falls in here too: length 0 at the current index
				if (g <= room) begin
					fresh.push_back('{m, idx, LEN_W'(g), LEN_W'(g), 1'b1});
				end else begin
					fresh.push_back('{m, idx, LEN_W'(room), LEN_W'(g), 1'b0});
					fresh.push_back('{m, '0, LEN_W'(g - room), LEN_W'(g), 1'b1});
				end
				if (m == MODE_WRITE)
					wr_total = wr_total + g;
				else
					rd_total = rd_total + g;
			end
			MODE_SYNC: begin
				diff = wr_total - sync_mark;
				widx = wr_total % rs;
				sidx = sync_mark % rs;
				if (diff == '0) begin
					fresh.push_back('{MODE_SYNC, base_reg + widx, '0, '0, 1'b1});
				end else begin
					// whole ring dirty: start from the write index and go all around
					if (diff >= rs || sidx == widx) begin
						sidx = widx;
						total = rs;
					end else if (sidx < widx) begin
						total = widx - sidx;
					end else begin
						total = rs - sidx + widx;
					end
					sync_mark = wr_total;
					if (sidx < widx) begin
						fresh.push_back('{MODE_SYNC, base_reg + sidx, LEN_W'(widx - sidx),
							LEN_W'(total), 1'b1});
					end else if (widx == '0) begin
						fresh.push_back('{MODE_SYNC, base_reg + sidx, LEN_W'(rs - sidx),
							LEN_W'(total), 1'b1});
					end else begin
						fresh.push_back('{MODE_SYNC, base_reg + sidx, LEN_W'(rs - sidx),
							LEN_W'(total), 1'b0});
						fresh.push_back('{MODE_SYNC, base_reg, LEN_W'(widx),
							LEN_W'(total), 1'b1});
					end
				end
			end
			default: ;
		endcase
	endfunction

	// everything on the block's outputs is looked at on the rising edge,
	// before the block's own updates of that edge land
	always @(posedge clk) begin : scoreboard
		seg_t got;
		seg_t want;
		if (arst_n) begin
			// results first, then a request taken at the same edge
			if (strobe) begin
				got = '{kind, offset, length, granted, last};
				if (segs_due.size() == 0) begin
					$error("unexpected result: kind %0d offset %0h length %0d granted %0d last %0d",
						got.kind, got.offset, got.length, got.granted, got.last);
					n_errors++;
				end else begin
					want = segs_due.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						n_errors++;
					end
					if (got.offset !== want.offset) begin
						$error("offset: expected %0h, got %0h", want.offset, got.offset);
						n_errors++;
					end
					if (got.length !== want.length) begin
						$error("length: expected %0d, got %0d", want.length, got.length);
						n_errors++;
					end
					if (got.granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted, got.granted);
						n_errors++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, got.last);
						n_errors++;
					end
				end
			end
			// register writes go into the shadow copy
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_RING_BYTES)
					ring_reg = cfg_data[LEN_W-1:0];
				else
					base_reg = cfg_data;
			end
			// request taken: predictor always runs to keep the counters in step,
			// a hand-written expectation replaces its output where one is given
			if (start && !busy) begin
				compute_segments(mode, request_length);
				if (typed_n < 0) begin
					foreach (fresh[i])
						segs_due.push_back(fresh[i]);
				end else if (typed_n == 1) begin
					segs_due.push_back(typed_seg);
				end
			end
		end
	end

	// hang detector: any handshake or result clears the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// present one request from the falling edge and hold it until taken;
	// start is left high so a following request can go out back to back
	task automatic send(input logic [MODE_W-1:0] m, input logic [CNT_W-1:0] len,
			input int n_typed, input seg_t want);
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		request_length <= len;
		typed_n = n_typed;
		typed_seg = want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// drop start for a pause whose length is given by n (n >= 1)
	task automatic pause_start(input int unsigned n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	// stop sending until every owed result has come out
	task automatic drain();
		pause_start(1);
		while (segs_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// new ring size and data base, only with the block idle; a dropped
	// unknown-mode request leaves nothing owed, hence the extra wait
	task automatic retune(input logic [LEN_W-1:0] ring, input logic [CNT_W-1:0] base);
		logic [CNT_W-LEN_W-1:0] junk;
		drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		// bits above the register width must be ignored
		junk = $urandom_range(0, 1) ? (CNT_W-LEN_W)'($urandom) : '0;
		write_reg(REG_RING_BYTES, {junk, ring});
		write_reg(REG_DATA_BASE, base);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		// ring sizes per phase: small, odd, the extremes, out of range;
		// going from large to small leaves overfull rings behind
		logic [LEN_W-1:0] phase_ring [N_PHASES] = '{
			17'd16, 17'd1, 17'd0, 17'd3, 17'd65536, 17'd131071, 17'd100,
			17'd7, 17'd2, 17'd65535, 17'd4096, 17'd12, 17'd5000
		};
		logic [MODE_W-1:0] m;
		logic [CNT_W-1:0]  len;
		logic [CNT_W-1:0]  rs;
		logic [LEN_W-1:0]  ring;
		logic [CNT_W-1:0]  base;
		int unsigned       pick;
		int unsigned       gap;
		int unsigned       sent;
		bit                no_idle;

		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n <= 1'b1;

		// directed requests on the reset settings
		foreach (dir_rows[i])
			send(dir_rows[i].op, dir_rows[i].req, dir_rows[i].n_typed, dir_rows[i].want);

		// random phases, one ring setting each
		for (int p = 0; p < N_PHASES; p++) begin
			ring = (p == N_PHASES - 1) ? LEN_W'($urandom_range(1, RING_MAX)) : phase_ring[p];
			case (p % 3)
				0: base = 32'hFFFF_FFFF;
				1: base = $urandom;
				default: base = '0;
			endcase
			retune(ring, base);
			no_idle = (p % 4 == 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				rs = ring_eff();
				pick = $urandom_range(0, 99);
				if (pick < 40)
					m = MODE_WRITE;
				else if (pick < 75)
					m = MODE_READ;
				else if (pick < 95)
					m = MODE_SYNC;
				else
					m = MODE_NONE;
				// lengths around the ring size matter most, plus the extremes
				case ($urandom_range(0, 11))
					0: len = '0;
					1: len = $urandom;
					2: len = '1;
					3: len = rs;
					4: len = rs + $urandom_range(1, 3);
					5, 6: len = $urandom_range(1, 4);
					default: len = $urandom_range(1, rs);
				endcase
				send(m, len, -1, '0);
				if (m != MODE_NONE)
					sent++;
				// mostly back to back, some short gaps, a few long ones
				pick = $urandom_range(0, 99);
				if (no_idle || pick < 60)
					gap = 0;
				else if (pick < 92)
					gap = $urandom_range(1, 4);
				else
					gap = $urandom_range(20, 120);
				if ($urandom_range(0, 99) < 3)
					drain();
				else if (gap != 0)
					pause_start(gap);
			end
		end

		drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (segs_due.size() != 0) begin
			$error("%0d results never arrived", segs_due.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== ring_buffer_segment_manager_top.f =====
design/rbsm_pkg.sv
design/rbsm_div.sv
design/ring_buffer_segment_manager_top.sv
tb/testbench.sv
